FILE: hdl/utfcm_pkg.sv
// Shared constants, case tables, item types and table helpers for the UTF-16 case mapper.
package utfcm_pkg;

    // Paired case tables, packed as uppercase hex digits: lower and upper
    // spellings of the same letter stand at the same entry index.
    localparam ROM_LO3 = "1313BC10110310510710910B10D10F11111311511711911B11D11F12112312512712912B12D12F06913313513713A13C13E14014214414614814B14D14F15115315515715915B15D15F16116316516716916B16D16F1711731751770FF17A17C17E07325318318525418825625718C1DD25925B19226026326926819926F2722751A11A31A52801A82831AD2881B028A28B1B41B62921B91BD1C61C61C91C91CC1CC1CE1D01D21D41D61D81DA1DC1DF1E11E31E51E71E91EB1ED1EF1F31F31F51951BF1F91FB1FD1FF20120320520720920B20D20F21121321521721921B21D21F19E22322522722922B22D22F2312333B93AC3AD3AE3AF3CC3CD3CE3B13B23B33B43B53B63B73B83B93BA3BB3BC3BD3BE3BF3C03C13C33C43C53C63C73C83C93CA3CB3C33B23B83C63C03D93DB3DD3DF3E13E33E53E73E93EB3ED3EF3BA3C13B83B53F83F23FB45045145245345445545645745845945A45B45C45D45E45F43043143243343443543643743843943A43B43C43D43E43F44044144244344444544644744844944A44B44C44D44E44F46146346546746946B46D46F47147347547747947B47D47F48148B48D48F49149349549749949B49D49F4A14A34A54A74A94AB4AD4AF4B14B34B54B74B94BB4BD4BF4C24C44C64C84CA4CC4CE4D14D34D54D74D94DB4DD4DF4E14E34E54E74E94EB4ED4EF4F14F34F54F950150350550750950B50D50F56156256356456556656756856956A56B56C56D56E56F57057157257357457557657757857957A57B57C57D57E57F580581582583584585586";
    localparam ROM_LO4 = "1E011E031E051E071E091E0B1E0D1E0F1E111E131E151E171E191E1B1E1D1E1F1E211E231E251E271E291E2B1E2D1E2F1E311E331E351E371E391E3B1E3D1E3F1E411E431E451E471E491E4B1E4D1E4F1E511E531E551E571E591E5B1E5D1E5F1E611E631E651E671E691E6B1E6D1E6F1E711E731E751E771E791E7B1E7D1E7F1E811E831E851E871E891E8B1E8D1E8F1E911E931E951E611EA11EA31EA51EA71EA91EAB1EAD1EAF1EB11EB31EB51EB71EB91EBB1EBD1EBF1EC11EC31EC51EC71EC91ECB1ECD1ECF1ED11ED31ED51ED71ED91EDB1EDD1EDF1EE11EE31EE51EE71EE91EEB1EED1EEF1EF11EF31EF51EF71EF91F001F011F021F031F041F051F061F071F101F111F121F131F141F151F201F211F221F231F241F251F261F271F301F311F321F331F341F351F361F371F401F411F421F431F441F451F511F531F551F571F601F611F621F631F641F651F661F671F801F811F821F831F841F851F861F871F901F911F921F931F941F951F961F971FA01FA11FA21FA31FA41FA51FA61FA71FB01FB11F701F711FB303B91F721F731F741F751FC31FD01FD11F761F771FE01FE11F7A1F7B1FE51F781F791F7C1F7D1FF303C9006B00E52170217121722173217421752176217721782179217A217B217C217D217E217F24D024D124D224D324D424D524D624D724D824D924DA24DB24DC24DD24DE24DF24E024E124E224E324E424E524E624E724E824E9FF41FF42FF43FF44FF45FF46FF47FF48FF49FF4AFF4BFF4CFF4DFF4EFF4FFF50FF51FF52FF53FF54FF55FF56FF57FF58FF59FF5A";
    localparam ROM_UP3 = "0490B510010210410610810A10C10E11011211411611811A11C11E12012212412612812A12C12E13013213413613913B13D13F14114314514714A14C14E15015215415615815A15C15E16016216416616816A16C16E17017217417617817917B17D17F18118218418618718918A18B18E18F19019119319419619719819C19D19F1A01A21A41A61A71A91AC1AE1AF1B11B21B31B51B71B81BC1C41C51C71C81CA1CB1CD1CF1D11D31D51D71D91DB1DE1E01E21E41E61E81EA1EC1EE1F11F21F41F61F71F81FA1FC1FE20020220420620820A20C20E21021221421621821A21C21E22022222422622822A22C22E23023234538638838938A38C38E38F39139239339439539639739839939A39B39C39D39E39F3A03A13A33A43A53A63A73A83A93AA3AB3C23D03D13D53D63D83DA3DC3DE3E03E23E43E63E83EA3EC3EE3F03F13F43F53F73F93FA40040140240340440540640740840940A40B40C40D40E40F41041141241341441541641741841941A41B41C41D41E41F42042142242342442542642742842942A42B42C42D42E42F46046246446646846A46C46E47047247447647847A47C47E48048A48C48E49049249449649849A49C49E4A04A24A44A64A84AA4AC4AE4B04B24B44B64B84BA4BC4BE4C14C34C54C74C94CB4CD4D04D24D44D64D84DA4DC4DE4E04E24E44E64E84EA4EC4EE4F04F24F44F850050250450650850A50C50E53153253353453553653753853953A53B53C53D53E53F54054154254354454554654754854954A54B54C54D54E54F550551552553554555556";
    localparam ROM_UP4 = "1E001E021E041E061E081E0A1E0C1E0E1E101E121E141E161E181E1A1E1C1E1E1E201E221E241E261E281E2A1E2C1E2E1E301E321E341E361E381E3A1E3C1E3E1E401E421E441E461E481E4A1E4C1E4E1E501E521E541E561E581E5A1E5C1E5E1E601E621E641E661E681E6A1E6C1E6E1E701E721E741E761E781E7A1E7C1E7E1E801E821E841E861E881E8A1E8C1E8E1E901E921E941E9B1EA01EA21EA41EA61EA81EAA1EAC1EAE1EB01EB21EB41EB61EB81EBA1EBC1EBE1EC01EC21EC41EC61EC81ECA1ECC1ECE1ED01ED21ED41ED61ED81EDA1EDC1EDE1EE01EE21EE41EE61EE81EEA1EEC1EEE1EF01EF21EF41EF61EF81F081F091F0A1F0B1F0C1F0D1F0E1F0F1F181F191F1A1F1B1F1C1F1D1F281F291F2A1F2B1F2C1F2D1F2E1F2F1F381F391F3A1F3B1F3C1F3D1F3E1F3F1F481F491F4A1F4B1F4C1F4D1F591F5B1F5D1F5F1F681F691F6A1F6B1F6C1F6D1F6E1F6F1F881F891F8A1F8B1F8C1F8D1F8E1F8F1F981F991F9A1F9B1F9C1F9D1F9E1F9F1FA81FA91FAA1FAB1FAC1FAD1FAE1FAF1FB81FB91FBA1FBB1FBC1FBE1FC81FC91FCA1FCB1FCC1FD81FD91FDA1FDB1FE81FE91FEA1FEB1FEC1FF81FF91FFA1FFB1FFC2126212A212B2160216121622163216421652166216721682169216A216B216C216D216E216F24B624B724B824B924BA24BB24BC24BD24BE24BF24C024C124C224C324C424C524C624C724C824C924CA24CB24CC24CD24CE24CFFF21FF22FF23FF24FF25FF26FF27FF28FF29FF2AFF2BFF2CFF2DFF2EFF2FFF30FF31FF32FF33FF34FF35FF36FF37FF38FF39FF3A";

    localparam int LEN_LO3 = $bits(ROM_LO3) / 8;
    localparam int LEN_UP3 = $bits(ROM_UP3) / 8;
    localparam int LEN_LO4 = $bits(ROM_LO4) / 8;
    localparam int LEN_UP4 = $bits(ROM_UP4) / 8;

    // a search covers the shorter table of each pair
    localparam int N3 = ((LEN_LO3 < LEN_UP3) ? LEN_LO3 : LEN_UP3) / 3;
    localparam int N4 = ((LEN_LO4 < LEN_UP4) ? LEN_LO4 : LEN_UP4) / 4;

    localparam int MAX_LEN3 = (LEN_LO3 > LEN_UP3) ? LEN_LO3 : LEN_UP3;
    localparam int MAX_LEN4 = (LEN_LO4 > LEN_UP4) ? LEN_LO4 : LEN_UP4;
    localparam int MAX_LEN  = (MAX_LEN3 > MAX_LEN4) ? MAX_LEN3 : MAX_LEN4;
    localparam int MAX_BITS = MAX_LEN * 8;

    localparam int CHAR_W        = 16;
    localparam int QUEUE_DEPTH_D = 4;

    // operations
    localparam logic OP_LOWER = 1'b0;
    localparam logic OP_UPPER = 1'b1;

    // item classes decided by the front end
    localparam logic [1:0] KIND_DIRECT = 2'd0;
    localparam logic [1:0] KIND_T3     = 2'd1;
    localparam logic [1:0] KIND_T4     = 2'd2;

    localparam logic [CHAR_W-1:0] CASE_SHIFT  = 16'd32;
    localparam logic [CHAR_W-1:0] CH_TIMES    = 16'd215;
    localparam logic [CHAR_W-1:0] CH_DIVIDE   = 16'd247;
    localparam logic [CHAR_W-1:0] CH_LATIN_HI = 16'h00FF;
    localparam logic [CHAR_W-1:0] CH_WIDE_LO  = 16'h1000;
    localparam logic [CHAR_W-1:0] CH_OHM      = 16'h2126;
    localparam logic [CHAR_W-1:0] CH_OMEGA_LC = 16'h03C9;
    localparam logic [CHAR_W-1:0] CH_KELVIN   = 16'h212A;
    localparam logic [CHAR_W-1:0] CH_K_LC     = 16'h006B;
    localparam logic [CHAR_W-1:0] CH_ANGSTROM = 16'h212B;
    localparam logic [CHAR_W-1:0] CH_ARING_LC = 16'h00E5;
    localparam logic [CHAR_W-1:0] CH_PROSGEG  = 16'h1FBE;
    localparam logic [CHAR_W-1:0] CH_IOTA_UC  = 16'h0399;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] ch;
        logic [1:0]        kind;
        logic [CHAR_W-1:0] dval;
    } item_t;

    function automatic logic [3:0] nib(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h41 + 8'd10);
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] rom_entry(input logic [MAX_LEN*8-1:0] s,
                                                    input int len, input int idx,
                                                    input int digits);
        logic [CHAR_W-1:0] v;
        int p;
        v = '0;
        for (int k = 0; k < 4; k++) begin
            if (k < digits) begin
                p = len - 1 - (idx * digits + k);
                v = {v[11:0], nib(s[p*8 +: 8])};
            end
        end
        return v;
    endfunction

    function automatic logic [N3*CHAR_W-1:0] build3(input logic [MAX_LEN*8-1:0] s,
                                                    input int len);
        logic [N3*CHAR_W-1:0] t;
        t = '0;
        for (int i = 0; i < N3; i++)
            t[i*CHAR_W +: CHAR_W] = rom_entry(s, len, i, 3);
        return t;
    endfunction

    function automatic logic [N4*CHAR_W-1:0] build4(input logic [MAX_LEN*8-1:0] s,
                                                    input int len);
        logic [N4*CHAR_W-1:0] t;
        t = '0;
        for (int i = 0; i < N4; i++)
            t[i*CHAR_W +: CHAR_W] = rom_entry(s, len, i, 4);
        return t;
    endfunction

    localparam logic [N3*CHAR_W-1:0] TAB_LO3 = build3(MAX_BITS'(ROM_LO3), LEN_LO3);
    localparam logic [N3*CHAR_W-1:0] TAB_UP3 = build3(MAX_BITS'(ROM_UP3), LEN_UP3);
    localparam logic [N4*CHAR_W-1:0] TAB_LO4 = build4(MAX_BITS'(ROM_LO4), LEN_LO4);
    localparam logic [N4*CHAR_W-1:0] TAB_UP4 = build4(MAX_BITS'(ROM_UP4), LEN_UP4);

endpackage

FILE: hdl/utfcm_front.sv
// Front end: takes requests, sorts them into direct results or table lookups.
module utfcm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [15:0]           char_in,
    output logic                  push,
    output utfcm_pkg::item_t      push_item,
    input  logic                  q_ready
);
    import utfcm_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    item_t cls;
    logic  take;

    always_comb
    begin
        cls.op   = op;
        cls.ch   = char_in;
        cls.kind = KIND_DIRECT;
        cls.dval = char_in;
        if (op == OP_LOWER) begin
            if ((char_in inside {[16'h0041:16'h005A]}) ||
                ((char_in inside {[16'h00C0:16'h00DD]}) && char_in != CH_TIMES))
                cls.dval = char_in + CASE_SHIFT;
        end else begin
            if ((char_in inside {[16'h0061:16'h007A]}) ||
                ((char_in inside {[16'h00E0:16'h00FD]}) && char_in != CH_DIVIDE))
                cls.dval = char_in - CASE_SHIFT;
        end
        if (char_in > CH_LATIN_HI)
            cls.kind = (char_in < CH_WIDE_LO) ? KIND_T3 : KIND_T4;
    end

    assign push      = valid_reg;
    assign push_item = item_reg;
    assign in_stall  = valid_reg && !q_ready;
    assign take      = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (q_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= cls;
    end

endmodule

FILE: hdl/utfcm_queue.sv
// Short FIFO between the front end and the lookup back end.
module utfcm_queue #(
    parameter int DEPTH = utfcm_pkg::QUEUE_DEPTH_D
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  utfcm_pkg::item_t push_item,
    output logic             q_ready,
    output logic             q_valid,
    output utfcm_pkg::item_t q_item,
    input  logic             pop
);
    import utfcm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_ready = (count_reg != CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_ready && !(pop && q_valid)) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule

FILE: hdl/utfcm_search.sv
// Two-stage first-match search of a key in one pair of case tables.
module utfcm_search #(
    parameter int                 N      = utfcm_pkg::N3,
    parameter logic [N*16-1:0]    TAB_LO = utfcm_pkg::TAB_LO3,
    parameter logic [N*16-1:0]    TAB_UP = utfcm_pkg::TAB_UP3
) (
    input  logic        clk,
    input  logic        ld_a,
    input  logic        ld_b,
    input  logic        op,
    input  logic [15:0] key,
    output logic        hit,
    output logic [15:0] val
);
    import utfcm_pkg::*;

    localparam int NCH = (N + 31) / 32;
    localparam int CBW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IW  = CBW + 5;

    logic [NCH-1:0] hit_a_reg;
    logic [4:0]     loc_a_reg [NCH];
    logic           op_a_reg;
    logic [NCH-1:0] hit_c;
    logic [4:0]     loc_c [NCH];
    logic           hit_b_reg;
    logic [IW-1:0]  idx_b_reg;
    logic           op_b_reg;
    logic           hit_s;
    logic [IW-1:0]  idx_s;
    logic [15:0]    dst_lo [2**IW];
    logic [15:0]    dst_up [2**IW];

    // per chunk of 32 entries: any hit and the lowest matching position
    always_comb
    begin
        for (int c = 0; c < NCH; c++) begin
            hit_c[c] = 1'b0;
            loc_c[c] = '0;
            for (int j = 31; j >= 0; j--) begin
                if (c * 32 + j < N) begin
                    if (key == (op ? TAB_LO[(c*32+j)*16 +: 16] : TAB_UP[(c*32+j)*16 +: 16]))
                    begin
                        hit_c[c] = 1'b1;
                        loc_c[c] = 5'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_a) begin
            hit_a_reg <= hit_c;
            loc_a_reg <= loc_c;
            op_a_reg  <= op;
        end
    end

    // first chunk with a hit wins
    always_comb
    begin
        hit_s = 1'b0;
        idx_s = '0;
        for (int c = NCH - 1; c >= 0; c--) begin
            if (hit_a_reg[c]) begin
                hit_s = 1'b1;
                idx_s = {CBW'(c), loc_a_reg[c]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_b) begin
            hit_b_reg <= hit_s;
            idx_b_reg <= idx_s;
            op_b_reg  <= op_a_reg;
        end
    end

    for (genvar i = 0; i < 2**IW; i++) begin : g_dst
        if (i < N) begin : g_used
            assign dst_lo[i] = TAB_LO[i*16 +: 16];
            assign dst_up[i] = TAB_UP[i*16 +: 16];
        end else begin : g_pad
            assign dst_lo[i] = '0;
            assign dst_up[i] = '0;
        end
    end

    assign hit = hit_b_reg;
    assign val = op_b_reg ? dst_up[idx_b_reg] : dst_lo[idx_b_reg];

endmodule

FILE: hdl/utfcm_back.sv
// Back end: table search pipeline, special cases and the output register.
module utfcm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  utfcm_pkg::item_t q_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [15:0]      char_out
);
    import utfcm_pkg::*;

    logic        v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    item_t       it1_reg, it2_reg;
    logic [15:0] res_reg, res_c;
    logic        rdy1, rdy2, rdy3;
    logic        ld_a, ld_b, ld_c;
    logic        hit3, hit4;
    logic [15:0] val3, val4;

    assign rdy3 = !v3_reg || !out_stall;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pop  = q_valid && rdy1;
    assign ld_a = pop;
    assign ld_b = v1_reg && rdy2;
    assign ld_c = v2_reg && rdy3;

    utfcm_search #(.N(N3), .TAB_LO(TAB_LO3), .TAB_UP(TAB_UP3)) u_s3 (
        .clk(clk), .ld_a(ld_a), .ld_b(ld_b), .op(q_item.op), .key(q_item.ch),
        .hit(hit3), .val(val3)
    );

    utfcm_search #(.N(N4), .TAB_LO(TAB_LO4), .TAB_UP(TAB_UP4)) u_s4 (
        .clk(clk), .ld_a(ld_a), .ld_b(ld_b), .op(q_item.op), .key(q_item.ch),
        .hit(hit4), .val(val4)
    );

    always_comb
    begin
        res_c = it2_reg.dval;
        case (it2_reg.kind)
            KIND_T3:
                if (hit3)
                    res_c = val3;
            KIND_T4:
                if (hit4)
                    res_c = val4;
                else if (it2_reg.op == OP_LOWER) begin
                    if (it2_reg.ch == CH_OHM)
                        res_c = CH_OMEGA_LC;
                    else if (it2_reg.ch == CH_KELVIN)
                        res_c = CH_K_LC;
                    else if (it2_reg.ch == CH_ANGSTROM)
                        res_c = CH_ARING_LC;
                end else if (it2_reg.ch == CH_PROSGEG)
                    res_c = CH_IOTA_UC;
            default:
                res_c = it2_reg.dval;
        endcase
    end

    always_comb
    begin
        v1_next = ld_a ? 1'b1 : (ld_b ? 1'b0 : v1_reg);
        v2_next = ld_b ? 1'b1 : (ld_c ? 1'b0 : v2_reg);
        v3_next = ld_c ? 1'b1 : (rdy3 ? 1'b0 : v3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_a)
            it1_reg <= q_item;
        if (ld_b)
            it2_reg <= it1_reg;
        if (ld_c)
            res_reg <= res_c;
    end

    assign out_valid = v3_reg;
    assign char_out  = res_reg;

`ifndef NO_ASSERTIONS
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && out_stall) |=> (v3_reg && $stable(res_reg)))
        else $error("result dropped while stalled");
    a_direct_latin: assert property (@(posedge clk) disable iff (!rst_n)
        (ld_c && it2_reg.kind == KIND_DIRECT) |-> (it2_reg.ch <= CH_LATIN_HI))
        else $error("wide code classed as direct");
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> v2_reg)
        else $error("stage two lost an item");
`endif

endmodule

FILE: hdl/utf16_case_mapper.sv
// Top level of the UTF-16 simple case mapper.
// One request per cycle, sustained while the output is not stalled: op 0 maps
// char_in to lower case, op 1 to upper case, and every request gives exactly
// one char_out, in order. ASCII and Latin-1 letters are resolved in the front
// end; codes above 0xFF are matched against constant case tables in a two-stage
// compare pipeline (parallel compare in chunks of 32, then a first-chunk
// select), followed by the partner-table read and the sign/letter special
// cases into the output register. From accept to result a request passes the
// input register, the queue, the two search stage registers and the output
// register. The queue of QUEUE_DEPTH entries lets the front keep taking
// requests while the output is stalled, until the queue is full. No
// configuration, no clearing pass after reset.
module utf16_case_mapper #(
    parameter int QUEUE_DEPTH = utfcm_pkg::QUEUE_DEPTH_D
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [15:0] char_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] char_out
);
    import utfcm_pkg::*;

    logic  push, q_ready, q_valid, pop;
    item_t push_item, q_item;

    // classify and register the request
    utfcm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .char_in(char_in),
        .push(push), .push_item(push_item), .q_ready(q_ready)
    );

    // decouples classification from the lookup pipeline
    utfcm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_item(push_item), .q_ready(q_ready),
        .q_valid(q_valid), .q_item(q_item), .pop(pop)
    );

    // table search, special cases, output register
    utfcm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .char_out(char_out)
    );

endmodule
